### hw/rtl/hsfp_pkg.sv
// Shared types, character codes and the hex digit decoder for the
// status frame parser. No dependencies; used by hsfp_step and the top level.
`default_nettype none

package hsfp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MICROS_W = 32;
    localparam int unsigned STATUS_W = 8;
    localparam int unsigned BUTTON_W = 16;
    localparam int unsigned NIBBLE_W = 4;

    // Digits per field and the counter that walks them.
    localparam int unsigned MICROS_DIGITS = MICROS_W / NIBBLE_W;
    localparam int unsigned STATUS_DIGITS = STATUS_W / NIBBLE_W;
    localparam int unsigned BUTTON_DIGITS = BUTTON_W / NIBBLE_W;
    localparam int unsigned DIGIT_CNT_W   = $clog2(MICROS_DIGITS);

    localparam logic [BYTE_W-1:0] CHAR_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CHAR_TYPE  = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TYPE,
        ST_SEP_A,
        ST_MICROS,
        ST_SEP_B,
        ST_STATUS,
        ST_SEP_C,
        ST_BUTTONS
    } parse_state_t;

    typedef logic [DIGIT_CNT_W-1:0] digit_cnt_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t r;
        r.ok  = 1'b1;
        r.val = c[NIBBLE_W-1:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = c[NIBBLE_W-1:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            // Letters A..F sit at low nibble 1..6 in both cases.
            r.val = c[NIBBLE_W-1:0] + 4'd9;
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hsfp_step.sv
// Frame parsing state machine and field accumulators for one word per cycle while step is high.
// Depends on hsfp_pkg.
`default_nettype none

module hsfp_step
    import hsfp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    input  wire logic                rx_error,
    output logic                     emit,
    output logic [MICROS_W-1:0]      timestamp_micros,
    output logic [STATUS_W-1:0]      status_byte,
    output logic [BUTTON_W-1:0]      button_word
);

    parse_state_t              state_reg, state_next;
    digit_cnt_t                cnt_reg, cnt_next;
    logic [MICROS_W-1:0]       micros_reg, micros_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [BUTTON_W-1:0]       buttons_reg, buttons_next;

    hex_digit_t digit;
    logic       special;
    logic       line_end;

    assign digit    = hex_decode(rx_byte);
    assign line_end = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign special  = rx_error || (rx_byte == CHAR_BANG) || line_end;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (rx_error || line_end) begin
            state_next = ST_IDLE;
        end
        else if (rx_byte == CHAR_BANG) begin
            state_next = ST_TYPE;
        end
        else begin
            unique case (state_reg)
                ST_IDLE, ST_TYPE:
                begin
                    if (rx_byte == CHAR_TYPE) begin
                        state_next = ST_SEP_A;
                    end
                end
                ST_SEP_A:
                begin
                    state_next = (rx_byte == CHAR_SPACE) ? ST_MICROS : ST_IDLE;
                    cnt_next   = '0;
                end
                ST_SEP_B:
                begin
                    state_next = (rx_byte == CHAR_COLON) ? ST_STATUS : ST_IDLE;
                    cnt_next   = '0;
                end
                ST_SEP_C:
                begin
                    state_next = (rx_byte == CHAR_COLON) ? ST_BUTTONS : ST_IDLE;
                    cnt_next   = '0;
                end
                ST_MICROS:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!digit.ok) begin
                        state_next = ST_IDLE;
                    end
                    else if (cnt_reg == digit_cnt_t'(MICROS_DIGITS - 1)) begin
                        state_next = ST_SEP_B;
                    end
                end
                ST_STATUS:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!digit.ok) begin
                        state_next = ST_IDLE;
                    end
                    else if (cnt_reg == digit_cnt_t'(STATUS_DIGITS - 1)) begin
                        state_next = ST_SEP_C;
                    end
                end
                ST_BUTTONS:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!digit.ok || cnt_reg == digit_cnt_t'(BUTTON_DIGITS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Outputs and accumulators. Digits shift in from the low end, so a full
    // field ends up most significant digit first without any clearing.
    always_comb
    begin
        micros_next  = micros_reg;
        status_next  = status_reg;
        buttons_next = buttons_reg;
        emit         = 1'b0;
        if (!special && digit.ok) begin
            unique case (state_reg)
                ST_MICROS:
                begin
                    micros_next = {micros_reg[MICROS_W-NIBBLE_W-1:0], digit.val};
                end
                ST_STATUS:
                begin
                    status_next = {status_reg[STATUS_W-NIBBLE_W-1:0], digit.val};
                end
                ST_BUTTONS:
                begin
                    buttons_next = {buttons_reg[BUTTON_W-NIBBLE_W-1:0], digit.val};
                    emit = step && (cnt_reg == digit_cnt_t'(BUTTON_DIGITS - 1));
                end
                default:
                begin
                end
            endcase
        end
    end

    assign timestamp_micros = micros_reg;
    assign status_byte      = status_reg;
    assign button_word      = buttons_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else if (step) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            micros_reg  <= micros_next;
            status_reg  <= status_next;
            buttons_reg <= buttons_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hex_status_frame_parser_core.sv
// Top level of the status frame parser: input register, parse step, result register.
// Depends on hsfp_pkg and hsfp_step.
//
//   channel | handshake           | word
//   --------+---------------------+-------------------------------------------------
//   in      | in_valid / in_ready | rx_byte, rx_error
//   out     | out_valid/out_ready | timestamp_micros, status_byte, button_word
//
// One word is taken every cycle while no result waits for out_ready; the parser works
// on a word while it sits in the input register, so a result is written to the result
// register as its last word leaves the input register.
// The parser state and the result register set the single-cycle loop.
// Reset puts the parser in idle and empties both registers.
// While a result waits for out_ready, one more word is held in the input register.
`default_nettype none

module hex_status_frame_parser_core
    import hsfp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    input  wire logic                rx_error,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [MICROS_W-1:0]      timestamp_micros,
    output logic [STATUS_W-1:0]      status_byte,
    output logic [BUTTON_W-1:0]      button_word
);

    logic                hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0]   hold_byte_reg;
    logic                hold_err_reg;
    logic                out_valid_reg, out_valid_next;
    logic [MICROS_W-1:0] micros_out_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic [BUTTON_W-1:0] buttons_out_reg;

    logic                advance;
    logic                accept;
    logic                emit;
    logic [MICROS_W-1:0] step_micros;
    logic [STATUS_W-1:0] step_status;
    logic [BUTTON_W-1:0] step_buttons;

    // The held word moves on whenever the result register is free or emptying.
    assign advance  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign hold_valid_next = accept || (hold_valid_reg && !advance);
    assign out_valid_next  = emit || (out_valid_reg && !out_ready);

    hsfp_step u_step
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .rx_byte          (hold_byte_reg),
        .rx_error         (hold_err_reg),
        .emit             (emit),
        .timestamp_micros (step_micros),
        .status_byte      (step_status),
        .button_word      (step_buttons)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            hold_byte_reg <= rx_byte;
            hold_err_reg  <= rx_error;
        end
        if (emit) begin
            micros_out_reg  <= step_micros;
            status_out_reg  <= step_status;
            buttons_out_reg <= step_buttons;
        end
    end

    assign out_valid        = out_valid_reg;
    assign timestamp_micros = micros_out_reg;
    assign status_byte      = status_out_reg;
    assign button_word      = buttons_out_reg;

endmodule

`default_nettype wire
